[src/bplm_pkg.sv]
`default_nettype none

package bplm_pkg;

  // Timestamp arithmetic width; differences wrap modulo 2^TIME_BITS.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned STAMP_W   = 32;  // width of the time_ms field
  localparam int unsigned CFG_W     = 16;  // widest configuration register
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [TIME_BITS-1:0] time_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'd0,
    CFG_LONG     = 1'd1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    OUT_PRESS     = 3'd0,
    OUT_DEBOUNCED = 3'd1,
    OUT_STRAY     = 3'd2,
    OUT_SHORT     = 3'd3,
    OUT_LONG      = 3'd4,
    OUT_TICK      = 3'd5
  } outcome_e;

  typedef struct packed {
    logic [CFG_W-1:0] quiet_ms;
    logic [CFG_W-1:0] long_ms;
  } cfg_t;

  typedef struct packed {
    logic     led;
    mode_e    mode;
    outcome_e outcome;
  } res_t;

endpackage

`default_nettype wire

[src/bplm_in_if.sv]
`default_nettype none

interface bplm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] time_ms;

  modport source (output valid, output opcode, output time_ms, input ready);
  modport sink   (input valid, input opcode, input time_ms, output ready);
endinterface

`default_nettype wire

[src/bplm_out_if.sv]
`default_nettype none

interface bplm_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [1:0] mode;
  logic [2:0] outcome;

  modport source (output valid, output led_level, output mode, output outcome, input ready);
  modport sink   (input valid, input led_level, input mode, input outcome, output ready);
endinterface

`default_nettype wire

[src/bplm_cfg_regs.sv]
`default_nettype none

module bplm_cfg_regs
  import bplm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                      cfg_o
);

  logic [CFG_W-1:0] debounce_q, debounce_d;
  logic [CFG_W-1:0] long_q, long_d;

  // register write decode
  always_comb begin
    debounce_d = debounce_q;
    long_d     = long_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: debounce_d = cfg_wdata_i;
        CFG_LONG:     long_d     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_q     <= LONG_RST;
    end else begin
      debounce_q <= debounce_d;
      long_q     <= long_d;
    end
  end

  assign cfg_o.quiet_ms = debounce_q;
  assign cfg_o.long_ms  = long_q;

endmodule

`default_nettype wire

[src/bplm_engine.sv]
`default_nettype none

// Press/release/tick evaluation and the LED mode state. One request is
// evaluated per cycle when fire_i is high; state updates at that edge.
module bplm_engine
  import bplm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [STAMP_W-1:0] time_ms_i,
  input  wire cfg_t               cfg_i,
  output res_t                    res_o
);

  mode_e mode_q, mode_d;
  logic  led_q, led_d;
  logic  held_q, held_d;
  logic  seen_q, seen_d;
  time_t press_q, press_d;
  time_t last_q, last_d;

  time_t    now;
  time_t    gap;
  time_t    hold;
  logic     bounce;
  logic     is_long;
  outcome_e outcome;

  assign now     = time_t'(time_ms_i);
  assign gap     = now - last_q;
  assign hold    = now - press_q;
  assign bounce  = seen_q && (gap < time_t'(cfg_i.quiet_ms));
  assign is_long = !(hold < time_t'(cfg_i.long_ms));

  // next state and outcome for the current request
  always_comb begin
    mode_d  = mode_q;
    led_d   = led_q;
    held_d  = held_q;
    seen_d  = seen_q;
    press_d = press_q;
    last_d  = last_q;
    outcome = OUT_DEBOUNCED;
    case (op_e'(opcode_i))
      OP_TICK: begin
        if (mode_q == MODE_BLINK) led_d = !led_q;
        outcome = OUT_TICK;
      end
      OP_PRESS, OP_RELEASE: begin
        if (!bounce) begin
          last_d = now;
          seen_d = 1'b1;
          if (op_e'(opcode_i) == OP_PRESS) begin
            press_d = now;
            held_d  = 1'b1;
            outcome = OUT_PRESS;
          end else if (!held_q) begin
            outcome = OUT_STRAY;
          end else begin
            held_d = 1'b0;
            if (!is_long) begin
              outcome = OUT_SHORT;
              if (mode_q == MODE_OFF) begin
                mode_d = MODE_ON;
                led_d  = 1'b1;
              end else begin
                mode_d = MODE_OFF;
                led_d  = 1'b0;
              end
            end else begin
              outcome = OUT_LONG;
              if (mode_q == MODE_BLINK) begin
                mode_d = MODE_OFF;
                led_d  = 1'b0;
              end else begin
                mode_d = MODE_BLINK;
              end
            end
          end
        end
      end
      default: outcome = OUT_DEBOUNCED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      led_q   <= 1'b0;
      held_q  <= 1'b0;
      seen_q  <= 1'b0;
      press_q <= '0;
      last_q  <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      led_q   <= led_d;
      held_q  <= held_d;
      seen_q  <= seen_d;
      press_q <= press_d;
      last_q  <= last_d;
    end
  end

  // result reflects the state after this request
  assign res_o.led     = led_d;
  assign res_o.mode    = mode_d;
  assign res_o.outcome = outcome;

  // an accepted press arms the hold measurement
  a_press_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && outcome == OUT_PRESS |=> held_q && last_q == $past(now))
    else $error("press did not arm hold measurement");

  // a debounced request leaves mode, LED, last stamp and held flag untouched
  a_bounce_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && outcome == OUT_DEBOUNCED |=>
      $stable(mode_q) && $stable(led_q) && $stable(last_q) && $stable(held_q))
    else $error("debounced request changed state");

  // leaving blink on a release always lands dark in off
  a_blink_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && mode_q == MODE_BLINK && (outcome == OUT_SHORT || outcome == OUT_LONG)
      |=> mode_q == MODE_OFF && !led_q)
    else $error("release in blink did not return to off");

endmodule

`default_nettype wire

[src/button_press_led_mode_controller.sv]
`default_nettype none

// Button press LED mode controller. Each request is a timestamped button
// press, a button release or a blink tick, and yields exactly one response
// carrying the LED level, the mode and an outcome code. The block takes one
// request per cycle while the response side keeps up, and carries each
// request through the input register, then its response through the
// response register; the evaluation is two wrap-around subtracts and
// compares, against the debounce window and the long press threshold. Both
// registers advance when the response register is empty or being taken;
// the input register also takes a request whenever it is empty, so one
// waiting response does not block the next request. Configuration writes
// take effect at the next edge and are expected while no request is in flight.
module button_press_led_mode_controller
  import bplm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  bplm_in_if.sink                   req_i,
  bplm_out_if.source                rsp_o
);

  cfg_t cfg;
  res_t res;

  logic               in_valid_q, in_valid_d;
  logic [1:0]         in_op_q;
  logic [STAMP_W-1:0] in_time_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_res_q;
  logic               adv;
  logic               fire;
  logic               req_take;

  bplm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipeline advance control
  assign adv         = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && adv;
  assign req_i.ready = !in_valid_q || adv;
  assign req_take    = req_i.valid && req_i.ready;
  assign in_valid_d  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_op_q   <= req_i.opcode;
      in_time_q <= req_i.time_ms;
    end
  end

  bplm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .opcode_i  (in_op_q),
    .time_ms_i (in_time_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.led_level = out_res_q.led;
  assign rsp_o.mode      = out_res_q.mode;
  assign rsp_o.outcome   = out_res_q.outcome;

endmodule

`default_nettype wire

[bench/button_press_led_mode_controller_tb.sv]
`default_nettype none

module button_press_led_mode_controller_tb;
  import bplm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One row of the directed sequence; known_ok marks a hand-typed response
  typedef struct {
    op_e   op;
    time_t stamp;
    bit    known_ok;
    res_t  known;
  } press_row_t;

  localparam res_t ANY_RES = '{1'b0, MODE_OFF, OUT_PRESS};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  bplm_in_if  req_if();
  bplm_out_if rsp_if();

  button_press_led_mode_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the controller state and its registers
  logic [CFG_W-1:0] debounce_q = DEBOUNCE_RST;
  logic [CFG_W-1:0] long_q     = LONG_RST;
  mode_e            mode_q     = MODE_OFF;
  logic             led_q      = 1'b0;
  logic             held_q     = 1'b0;
  time_t            press_q    = '0;
  time_t            last_q     = '0;
  logic             seen_q     = 1'b0;

  res_t  led_mode_due[$];
  res_t  predicted;
  res_t  due;
  int    errors = 0;
  int    cycle_cnt = 0;
  int    send_idle_pct = 0;
  int    stall_pct = 0;
  logic  hold_rsp;
  logic  req_known_ok;
  res_t  req_known;
  time_t gen_stamp;
  bit    gen_pressed = 1'b0;

  // Directed sequence at reset settings (window 50, threshold 1000)
  press_row_t press_rows[22] = '{
    '{OP_TICK,    32'd0,          1'b1, '{1'b0, MODE_OFF,   OUT_TICK}},
    '{OP_RELEASE, 32'd0,          1'b1, '{1'b0, MODE_OFF,   OUT_STRAY}},
    '{OP_PRESS,   32'd10,         1'b1, '{1'b0, MODE_OFF,   OUT_DEBOUNCED}},
    '{OP_UNUSED,  32'd5,          1'b1, '{1'b0, MODE_OFF,   OUT_DEBOUNCED}},
    '{OP_PRESS,   32'd100,        1'b0, ANY_RES},
    '{OP_RELEASE, 32'd300,        1'b0, ANY_RES},
    '{OP_TICK,    32'd0,          1'b0, ANY_RES},
    '{OP_PRESS,   32'd1000,       1'b0, ANY_RES},
    '{OP_RELEASE, 32'd2000,       1'b0, ANY_RES},
    '{OP_TICK,    32'hFFFF_FFFF,  1'b0, ANY_RES},
    '{OP_TICK,    32'd0,          1'b0, ANY_RES},
    '{OP_PRESS,   32'd2049,       1'b1, '{1'b1, MODE_BLINK, OUT_DEBOUNCED}},
    '{OP_PRESS,   32'd2050,       1'b0, ANY_RES},
    '{OP_RELEASE, 32'd3049,       1'b0, ANY_RES},
    '{OP_PRESS,   32'hFFFF_FF00,  1'b0, ANY_RES},
    '{OP_RELEASE, 32'h0000_0300,  1'b1, '{1'b0, MODE_BLINK, OUT_LONG}},
    '{OP_TICK,    32'd0,          1'b0, ANY_RES},
    '{OP_PRESS,   32'h0001_0000,  1'b0, ANY_RES},
    '{OP_RELEASE, 32'h0001_1388,  1'b0, ANY_RES},
    '{OP_RELEASE, 32'hFFFF_FFFF,  1'b1, '{1'b0, MODE_OFF,   OUT_STRAY}},
    '{OP_PRESS,   32'hFFFF_FFF0,  1'b0, ANY_RES},
    '{OP_PRESS,   32'h0000_0020,  1'b1, '{1'b0, MODE_OFF,   OUT_DEBOUNCED}}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the shadow state by one request and return its response
  function automatic res_t advance_led_mode(op_e op, time_t now);
    res_t  r;
    time_t gap;
    time_t held;
    r.outcome = OUT_DEBOUNCED;
    gap  = now - last_q;
    held = now - press_q;
    case (op)
      OP_TICK: begin
        if (mode_q == MODE_BLINK) led_q = ~led_q;
        r.outcome = OUT_TICK;
      end
      OP_PRESS, OP_RELEASE: begin
        if (!(seen_q && gap < debounce_q)) begin
          last_q = now;
          seen_q = 1'b1;
          if (op == OP_PRESS) begin
            press_q   = now;
            held_q    = 1'b1;
            r.outcome = OUT_PRESS;
          end else if (!held_q) begin
            r.outcome = OUT_STRAY;
          end else begin
            held_q = 1'b0;
            if (held < long_q) begin
              r.outcome = OUT_SHORT;
              if (mode_q == MODE_OFF) begin
                mode_q = MODE_ON;
                led_q  = 1'b1;
              end else begin
                mode_q = MODE_OFF;
                led_q  = 1'b0;
              end
            end else begin
              r.outcome = OUT_LONG;
              if (mode_q == MODE_BLINK) begin
                mode_q = MODE_OFF;
                led_q  = 1'b0;
              end else begin
                mode_q = MODE_BLINK;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.led  = led_q;
    r.mode = mode_q;
    return r;
  endfunction

  // Gap to the next button event, often close to the window or threshold
  function automatic time_t pick_gap(bit is_release);
    time_t edge_ms;
    edge_ms = is_release ? time_t'(long_q) : time_t'(debounce_q);
    case ($urandom_range(0, 7))
      0, 1, 2: return edge_ms + $urandom_range(0, 2) - 1;
      3:       return $urandom_range(0, edge_ms);
      4, 5:    return $urandom_range(0, 3000);
      6:       return $urandom;
      default: return edge_ms + $urandom_range(0, 500);
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(op_e op, time_t stamp, bit known_ok, res_t known);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.time_ms <= stamp;
    req_known_ok   <= known_ok;
    req_known      <= known;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Mostly press/release pairs with gaps near the limits, plus ticks and noise
  task automatic send_random(int n);
    op_e   op;
    time_t stamp;
    int    pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        op    = OP_TICK;
        stamp = $urandom;
      end else if (pick < 80) begin
        op          = gen_pressed ? OP_RELEASE : OP_PRESS;
        gen_stamp   = gen_stamp + pick_gap(gen_pressed);
        stamp       = gen_stamp;
        gen_pressed = !gen_pressed;
      end else begin
        op        = op_e'($urandom_range(0, 3));
        stamp     = $urandom_range(0, 1) ? $urandom : gen_stamp + $urandom_range(0, 100);
        gen_stamp = stamp;
      end
      send_request(op, stamp, 1'b0, ANY_RES);
    end
    req_if.valid <= 1'b0;
  endtask

  // Wait until every response is in, then let the pipeline settle
  task automatic drain_responses();
    do @(negedge clk_i); while (led_mode_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both registers, one per edge
  task automatic write_config(logic [CFG_W-1:0] window_ms, logic [CFG_W-1:0] thresh_ms);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEBOUNCE;
    cfg_wdata_i <= window_ms;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LONG;
    cfg_wdata_i <= thresh_ms;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    debounce_q  = window_ms;
    long_q      = thresh_ms;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] window_ms, logic [CFG_W-1:0] thresh_ms,
                           int idle_pct, int stall, int n);
    drain_responses();
    write_config(window_ms, thresh_ms);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    send_random(n);
  endtask

  // Response side: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    rsp_if.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
  end

  // Predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      predicted = advance_led_mode(op_e'(req_if.opcode), req_if.time_ms);
      led_mode_due.push_back(req_known_ok ? req_known : predicted);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (led_mode_due.size() == 0) begin
        $display("%0t: response with nothing outstanding (led %0b mode %0d outcome %0d)",
                 $time, rsp_if.led_level, rsp_if.mode, rsp_if.outcome);
        errors++;
      end else begin
        due = led_mode_due.pop_front();
        if (rsp_if.led_level !== due.led) begin
          $display("%0t: led_level expected %0b actual %0b", $time, due.led, rsp_if.led_level);
          errors++;
        end
        if (rsp_if.mode !== due.mode) begin
          $display("%0t: mode expected %0d actual %0d", $time, due.mode, rsp_if.mode);
          errors++;
        end
        if (rsp_if.outcome !== due.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, due.outcome, rsp_if.outcome);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DEBOUNCE;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.opcode  = OP_PRESS;
    req_if.time_ms = '0;
    rsp_if.ready   = 1'b0;
    hold_rsp       = 1'b0;
    req_known_ok   = 1'b0;
    req_known      = ANY_RES;
    gen_stamp      = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings
    foreach (press_rows[i])
      send_request(press_rows[i].op, press_rows[i].stamp, press_rows[i].known_ok,
                   press_rows[i].known);
    req_if.valid <= 1'b0;

    run_phase(16'd0, 16'd0, 0, 0, 100);
    run_phase(16'hFFFF, 16'hFFFF, 84, 0, 100);
    run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(100, 3000)), 0, 84, 100);
    run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(100, 3000)), 28, 28, 100);

    // long receiver hold-off while requests keep coming
    drain_responses();
    write_config(DEBOUNCE_RST, LONG_RST);
    send_idle_pct = 0;
    stall_pct     = 0;
    fork
      send_random(100);
      begin
        hold_rsp <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rsp <= 1'b0;
      end
    join

    run_phase(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 400)), 10, 10, 100);
    drain_responses();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
